[rtl/srht_pkg.sv]
// Shared types and constants for the segment/rectangle hit test.
// Used by srht_cfg_regs and segment_rectangle_hit_test; no dependencies.
`timescale 1ns / 1ps

package srht_pkg;

  // Segment coordinates: signed two's complement.
  localparam int COORD_BITS = 13;
  // Rectangle registers: unsigned.
  localparam int REG_BITS   = 11;
  // Right and bottom coordinates (left + width, top + height) never wrap.
  localparam int EDGE_BITS  = REG_BITS + 1;
  // Common signed operand width for all differences and deltas.
  localparam int OP_BITS    = ((COORD_BITS > EDGE_BITS + 1) ? COORD_BITS : EDGE_BITS + 1) + 1;
  localparam int PROD_BITS  = 2 * OP_BITS;
  localparam int TN_BITS    = PROD_BITS + 1;

  // Configuration port geometry.
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 4;
  localparam int ADDR_LSB     = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OP_BITS-1:0]    op_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [TN_BITS-1:0]    tn_t;

  // Register indexes, in register map order.
  typedef enum logic [ADDR_BITS-ADDR_LSB-1:0] {
    REG_RECT_LEFT = 2'd0,
    REG_RECT_TOP  = 2'd1,
    REG_RECT_W    = 2'd2,
    REG_RECT_H    = 2'd3
  } reg_idx_t;

  // Rectangle as held in the register file.
  typedef struct packed {
    logic [REG_BITS-1:0] left;
    logic [REG_BITS-1:0] top;
    logic [REG_BITS-1:0] w;
    logic [REG_BITS-1:0] h;
  } rect_cfg_t;

endpackage

[rtl/segment_rectangle_hit_test.sv]
// Top level of the segment/rectangle hit test: four-stage pipeline.
// Depends on srht_pkg and instantiates srht_cfg_regs.
`timescale 1ns / 1ps

// The block takes one segment item per clock when the output side is not
// stalled and returns one hit item for each, in order. The stages are:
// input register, differences and the endpoint inside test, twelve parallel
// 14x14 signed products (the stage that sets the clock), then the cross
// product subtractions and sign tests feeding the output register. Every
// stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so bubbles close up and new items are still taken while a
// result waits at the output. The rectangle registers must only be written
// while no item is in flight.
module segment_rectangle_hit_test
  import srht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  // Edge test on normalized cross products: touching counts, parallel never.
  function automatic logic edge_ok(input tn_t den, input tn_t tn, input tn_t un);
    logic pos_ok;
    logic neg_ok;
    pos_ok = (tn >= 0) && (tn <= den) && (un >= 0) && (un <= den);
    neg_ok = (tn <= 0) && (tn >= den) && (un <= 0) && (un >= den);
    return (den != 0) && ((den > 0) ? pos_ok : neg_ok);
  endfunction

  rect_cfg_t rect;

  srht_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rect    (rect)
  );

  // Rectangle bounds as signed operands.
  logic [EDGE_BITS-1:0] right_u;
  logic [EDGE_BITS-1:0] bottom_u;
  op_t rl, rt, rr, rb, rw, rh;

  assign right_u  = {1'b0, rect.left} + {1'b0, rect.w};
  assign bottom_u = {1'b0, rect.top} + {1'b0, rect.h};
  assign rl = op_t'($signed({1'b0, rect.left}));
  assign rt = op_t'($signed({1'b0, rect.top}));
  assign rw = op_t'($signed({1'b0, rect.w}));
  assign rh = op_t'($signed({1'b0, rect.h}));
  assign rr = op_t'($signed({1'b0, right_u}));
  assign rb = op_t'($signed({1'b0, bottom_u}));

  // Per-stage ready chain.
  logic v0_r, v1_r, v2_r, out_valid_r;
  logic v0_nxt, v1_nxt, v2_nxt, out_valid_nxt;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3     = !out_valid_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_stall = !rdy0;

  // Stage 0: input register.
  coord_t ax_r, ay_r, bx_r, by_r;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      ax_r <= coord_t'(in_start_x);
      ay_r <= coord_t'(in_start_y);
      bx_r <= coord_t'(in_end_x);
      by_r <= coord_t'(in_end_y);
    end
  end

  // Stage 1: differences and the half-open endpoint inside test.
  op_t ax, ay, bx, by;
  op_t dx_nxt, dy_nxt, ndx_nxt, ndy_nxt;
  op_t exl_nxt, exr_nxt, eyt_nxt, eyb_nxt, nexl_nxt, neyt_nxt;
  logic inside_nxt;

  assign ax = op_t'(ax_r);
  assign ay = op_t'(ay_r);
  assign bx = op_t'(bx_r);
  assign by = op_t'(by_r);

  always_comb begin
    dx_nxt     = bx - ax;
    dy_nxt     = by - ay;
    ndx_nxt    = ax - bx;
    ndy_nxt    = ay - by;
    exl_nxt    = ax - rl;
    exr_nxt    = ax - rr;
    eyt_nxt    = ay - rt;
    eyb_nxt    = ay - rb;
    nexl_nxt   = rl - ax;
    neyt_nxt   = rt - ay;
    inside_nxt = ((ax >= rl) && (ax < rr) && (ay >= rt) && (ay < rb))
              || ((bx >= rl) && (bx < rr) && (by >= rt) && (by < rb));
  end

  op_t dx_r, dy_r, ndx_r, ndy_r, exl_r, exr_r, eyt_r, eyb_r, nexl_r, neyt_r;
  logic inside1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      ndx_r     <= ndx_nxt;
      ndy_r     <= ndy_nxt;
      exl_r     <= exl_nxt;
      exr_r     <= exr_nxt;
      eyt_r     <= eyt_nxt;
      eyb_r     <= eyb_nxt;
      nexl_r    <= nexl_nxt;
      neyt_r    <= neyt_nxt;
      inside1_r <= inside_nxt;
    end
  end

  // Stage 2: cross product terms. Edges run top (left to right), right
  // (top to bottom), bottom (right to left) and left (bottom to top).
  prod_t den_top_r, den_rgt_r, den_bot_r, den_lft_r;
  prod_t un_top_r, un_rgt_r, un_bot_r, un_lft_r;
  prod_t exl_dy_r, exr_dy_r, eyt_dx_r, eyb_dx_r;
  logic  inside2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      den_top_r <= rw * dy_r;
      den_rgt_r <= rh * ndx_r;
      den_bot_r <= rw * ndy_r;
      den_lft_r <= rh * dx_r;
      un_top_r  <= rw * neyt_r;
      un_rgt_r  <= rh * exr_r;
      un_bot_r  <= rw * eyb_r;
      un_lft_r  <= rh * nexl_r;
      exl_dy_r  <= exl_r * dy_r;
      exr_dy_r  <= exr_r * dy_r;
      eyt_dx_r  <= eyt_r * dx_r;
      eyb_dx_r  <= eyb_r * dx_r;
      inside2_r <= inside1_r;
    end
  end

  // Stage 3: edge parameter numerators and the edge tests for top, right, bottom and left.
  tn_t tn_top, tn_rgt, tn_bot, tn_lft;
  logic hit_nxt;

  always_comb begin
    tn_top  = tn_t'(exl_dy_r) - tn_t'(eyt_dx_r);
    tn_rgt  = tn_t'(exr_dy_r) - tn_t'(eyt_dx_r);
    tn_bot  = tn_t'(exr_dy_r) - tn_t'(eyb_dx_r);
    tn_lft  = tn_t'(exl_dy_r) - tn_t'(eyb_dx_r);
    hit_nxt = inside2_r
           || edge_ok(tn_t'(den_top_r), tn_top, tn_t'(un_top_r))
           || edge_ok(tn_t'(den_rgt_r), tn_rgt, tn_t'(un_rgt_r))
           || edge_ok(tn_t'(den_bot_r), tn_bot, tn_t'(un_bot_r))
           || edge_ok(tn_t'(den_lft_r), tn_lft, tn_t'(un_lft_r));
  end

  logic out_hit_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // Stage valid bits.
  always_comb begin
    v0_nxt        = rdy0 ? in_valid : v0_r;
    v1_nxt        = rdy1 ? v0_r     : v1_r;
    v2_nxt        = rdy2 ? v1_r     : v2_r;
    out_valid_nxt = rdy3 ? v2_r     : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= v0_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The input is held off only when every stage holds an item.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && out_valid_r))
    else $error("input stalled while the pipeline has a free stage");

  // An item in the input register that moves on lands in stage one.
  a_stage0_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && rdy1) |=> v1_r)
    else $error("item lost between input register and stage one");

  // An endpoint inside the rectangle always gives a hit.
  a_inside_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rdy3 && inside2_r) |=> (out_valid_r && out_hit_r))
    else $error("endpoint inside the rectangle did not give a hit");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

[rtl/srht_cfg_regs.sv]
// APB-style register file holding the rectangle for the hit test.
// Depends on srht_pkg for the register map and the rect_cfg_t struct.
`timescale 1ns / 1ps

module srht_cfg_regs
  import srht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output rect_cfg_t            rect
);

  rect_cfg_t rect_r;
  rect_cfg_t rect_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  // The word index is the byte address divided by four.
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:ADDR_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign rect   = rect_r;

  // Write decode: only the low register bits of the data are kept.
  always_comb begin
    rect_nxt = rect_r;
    if (wr_en) begin
      case (idx)
        REG_RECT_LEFT: rect_nxt.left = pwdata[REG_BITS-1:0];
        REG_RECT_TOP:  rect_nxt.top  = pwdata[REG_BITS-1:0];
        REG_RECT_W:    rect_nxt.w    = pwdata[REG_BITS-1:0];
        REG_RECT_H:    rect_nxt.h    = pwdata[REG_BITS-1:0];
        default:       rect_nxt      = rect_r;
      endcase
    end
  end

  // Read mux, zero extended to the bus width.
  always_comb begin
    case (idx)
      REG_RECT_LEFT: prdata = DATA_BITS'(rect_r.left);
      REG_RECT_TOP:  prdata = DATA_BITS'(rect_r.top);
      REG_RECT_W:    prdata = DATA_BITS'(rect_r.w);
      REG_RECT_H:    prdata = DATA_BITS'(rect_r.h);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_r <= '0;
    end else begin
      rect_r <= rect_nxt;
    end
  end

endmodule
